### design/tgcs_pkg.sv
// Package for the three-gate confidence score unit.
// Holds field widths, configuration register codes and the gate flag type.
// No dependencies.
package tgcs_pkg;

  localparam int SCORE_FRAC_BITS_DEF = 16;

  localparam int ACC_W   = 17;
  localparam int ROW_W   = 24;
  localparam int NORM_W  = 20;
  localparam int FLOOR_W = 17;
  localparam int OUT_W   = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STUCK_ACC   = 3'd0,
    CFG_GOOD_ACC    = 3'd1,
    CFG_CONF_COUNT  = 3'd2,
    CFG_LOW_INNOV   = 3'd3,
    CFG_HIGH_INNOV  = 3'd4,
    CFG_VALID_FLOOR = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    INNOV_ZERO,
    INNOV_ONE,
    INNOV_HALF
  } innov_sel_t;

  typedef struct packed {
    logic       stuck;
    logic       mix_one;
    logic       info_one;
    logic       info_zero;
    innov_sel_t innov_sel;
  } gate_flags_t;

endpackage

### design/three_gate_confidence_score_unit.sv
// Top level of the three-gate confidence score unit.
// Depends on tgcs_pkg, tgcs_div and tgcs_cbrt.
//
// Each input transaction (acceptance rate, smallest row count, change norm) yields exactly
// one output transaction holding the mixing, information and innovation gate scores, the
// floor cube root of their product and a valid flag. Scores are unsigned fixed point with
// SCORE_FRAC_BITS fraction bits, so at the default of 16 the value 65536 means 1.0. The unit
// is fully pipelined and accepts a transaction in every cycle while the output buffer
// has room. A result passes the input register, the two-lane divider, which resolves one
// quotient bit per stage, the product stages and the cube-root pipeline, which resolves
// one root bit per stage, and then the output register. A two-entry output buffer lets
// the pipeline keep taking transactions while a result waits, and s_tready only falls
// once that buffer is full. The configuration registers are read live by the pipeline,
// so they should be written only while no transaction is in flight.
module three_gate_confidence_score_unit #(
  parameter int SCORE_FRAC_BITS = tgcs_pkg::SCORE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // acceptance [16:0], row_count [40:17], change_norm [60:41], zero pad above
  input  logic [tgcs_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mixing [16:0], information [33:17], innovation [50:34],
  // overall_score [67:51], valid flag [68], zero pad above
  output logic [tgcs_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgcs_pkg::*;

  localparam int F  = SCORE_FRAC_BITS;
  localparam int SW = F + 1;
  localparam logic [SW-1:0] SCORE_ONE = {1'b1, {F{1'b0}}};
  // The floor threshold is unsigned Q1.16 and is rescaled to the score format.
  localparam int UP   = (F >= 16) ? F - 16 : 0;
  localparam int DOWN = (F < 16) ? 16 - F : 0;
  localparam int FLW  = FLOOR_W + 24;

  // Configuration registers.
  logic [ACC_W-1:0]   stuck_acceptance;
  logic [ACC_W-1:0]   full_mix_acceptance;
  logic [ROW_W-1:0]   confident_count;
  logic [NORM_W-1:0]  low_innovation;
  logic [NORM_W-1:0]  high_innovation;
  logic [FLOOR_W-1:0] valid_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      stuck_acceptance    <= ACC_W'(655);
      full_mix_acceptance <= ACC_W'(13107);
      confident_count     <= ROW_W'(12800);
      low_innovation      <= NORM_W'(655);
      high_innovation     <= NORM_W'(32768);
      valid_floor         <= FLOOR_W'(6554);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STUCK_ACC:   stuck_acceptance    <= cfg_data[ACC_W-1:0];
        CFG_GOOD_ACC:    full_mix_acceptance <= cfg_data[ACC_W-1:0];
        CFG_CONF_COUNT:  confident_count     <= cfg_data[ROW_W-1:0];
        CFG_LOW_INNOV:   low_innovation      <= cfg_data[NORM_W-1:0];
        CFG_HIGH_INNOV:  high_innovation     <= cfg_data[NORM_W-1:0];
        CFG_VALID_FLOOR: valid_floor         <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; it halts only when the output buffer is full.
  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign s_tready = en;

  // Input stage: all threshold comparisons, and the division operands.
  logic [ACC_W-1:0]  acc;
  logic [ROW_W-1:0]  rows;
  logic [NORM_W-1:0] norm;
  assign acc  = s_tdata[16:0];
  assign rows = s_tdata[40:17];
  assign norm = s_tdata[60:41];

  gate_flags_t           flags_in;
  gate_flags_t           flags0;
  logic [1:0][ROW_W-1:0] num0, den0;
  logic                  v0;

  always_comb begin
    flags_in.stuck     = acc < stuck_acceptance;
    flags_in.mix_one   = acc >= full_mix_acceptance;
    flags_in.info_one  = rows >= confident_count;
    flags_in.info_zero = rows == '0;
    if (norm < low_innovation) begin
      flags_in.innov_sel = INNOV_ZERO;
    end else if (norm > high_innovation) begin
      flags_in.innov_sel = INNOV_HALF;
    end else begin
      flags_in.innov_sel = INNOV_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  // The quotients are only used where the numerator is below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      flags0  <= flags_in;
      num0[0] <= ROW_W'(ACC_W'(acc - stuck_acceptance));
      den0[0] <= ROW_W'(ACC_W'(full_mix_acceptance - stuck_acceptance));
      num0[1] <= rows;
      den0[1] <= confident_count;
    end
  end

  logic               div_valid;
  gate_flags_t        div_flags;
  logic [1:0][F-1:0]  div_quo;

  tgcs_div #(
    .QW(F)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .flags_in  (flags0),
    .num       (num0),
    .den       (den0),
    .out_valid (div_valid),
    .flags_out (div_flags),
    .quo       (div_quo)
  );

  // Gate scores. A stuck chain forces all three to zero, which also zeroes the root.
  logic [SW-1:0] mix, info, innov;

  always_comb begin
    if (div_flags.stuck) begin
      mix = '0;
    end else if (div_flags.mix_one) begin
      mix = SCORE_ONE;
    end else begin
      mix = SW'(div_quo[0]);
    end
    if (div_flags.stuck) begin
      info = '0;
    end else if (div_flags.info_one) begin
      info = SCORE_ONE;
    end else if (div_flags.info_zero) begin
      info = '0;
    end else begin
      info = SW'(div_quo[1]);
    end
    if (div_flags.stuck) begin
      innov = '0;
    end else begin
      unique case (div_flags.innov_sel)
        INNOV_ZERO: innov = '0;
        INNOV_ONE:  innov = SCORE_ONE;
        INNOV_HALF: innov = mix >> 1;
        default:    innov = '0;
      endcase
    end
  end

  logic            cb_valid;
  logic [SW-1:0]   overall;
  logic [3*SW-1:0] cb_tag;

  tgcs_cbrt #(
    .SW(SW),
    .TW(3 * SW)
  ) u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .a         (mix),
    .b         (info),
    .c         (innov),
    .tag_in    ({innov, info, mix}),
    .out_valid (cb_valid),
    .root      (overall),
    .tag_out   (cb_tag)
  );

  // Result assembly.
  logic [FLW-1:0]       floor_q;
  logic                 score_ok;
  logic [M_TDATA_W-1:0] result;

  assign floor_q  = (FLW'(valid_floor) << UP) >> DOWN;
  assign score_ok = FLW'(overall) > floor_q;
  assign result   = {3'b000, score_ok, OUT_W'(overall), OUT_W'(cb_tag[3*SW-1:2*SW]),
                     OUT_W'(cb_tag[2*SW-1:SW]), OUT_W'(cb_tag[SW-1:0])};

  // Output register with a skid entry behind it.
  logic                 out_valid;
  logic [M_TDATA_W-1:0] out_data;
  logic [M_TDATA_W-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= cb_valid;
      end
    end else if (cb_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (!skid_valid) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### design/tgcs_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Carries the gate flags alongside. Depends on tgcs_pkg.
module tgcs_div #(
  parameter int QW = tgcs_pkg::SCORE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  tgcs_pkg::gate_flags_t                flags_in,
  input  logic [1:0][tgcs_pkg::ROW_W-1:0]      num,
  input  logic [1:0][tgcs_pkg::ROW_W-1:0]      den,
  output logic                                 out_valid,
  output tgcs_pkg::gate_flags_t                flags_out,
  output logic [1:0][QW-1:0]                   quo
);
  import tgcs_pkg::*;

  // Where a numerator is below its divisor the remainder stays below it and so fits ROW_W bits.
  logic [1:0][ROW_W-1:0] rem      [QW];
  logic [1:0][ROW_W-1:0] dvs      [QW];
  logic [1:0][QW-1:0]    qs       [QW];
  gate_flags_t           flg      [QW];
  logic [QW-1:0]         vld;

  logic [1:0][ROW_W-1:0] rem_prev [QW];
  logic [1:0][ROW_W-1:0] dvs_prev [QW];
  logic [1:0][QW-1:0]    qs_prev  [QW];
  gate_flags_t           flg_prev [QW];
  logic [1:0][ROW_W-1:0] rem_next [QW];
  logic [1:0][QW-1:0]    qs_next  [QW];

  always_comb begin
    rem_prev[0] = num;
    dvs_prev[0] = den;
    qs_prev[0]  = '0;
    flg_prev[0] = flags_in;
    for (int k = 1; k < QW; k++) begin
      rem_prev[k] = rem[k-1];
      dvs_prev[k] = dvs[k-1];
      qs_prev[k]  = qs[k-1];
      flg_prev[k] = flg[k-1];
    end
  end

  always_comb begin
    logic [ROW_W:0] t;
    logic           ge;
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < 2; l++) begin
        t  = {rem_prev[k][l], 1'b0};
        ge = t >= {1'b0, dvs_prev[k][l]};
        rem_next[k][l] = ge ? ROW_W'(t - {1'b0, dvs_prev[k][l]}) : t[ROW_W-1:0];
        qs_next[k][l]  = {qs_prev[k][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= rem_next[k];
        dvs[k] <= dvs_prev[k];
        qs[k]  <= qs_next[k];
        flg[k] <= flg_prev[k];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign flags_out = flg[QW-1];
  assign quo       = qs[QW-1];

endmodule

### design/tgcs_cbrt.sv
// Pipelined product of three scores and its floor cube root, one root bit per stage.
// The product is built from two narrow multiplier stages and an add stage. No dependencies.
module tgcs_cbrt #(
  parameter int SW = 17,
  parameter int TW = 51
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [SW-1:0] a,
  input  logic [SW-1:0] b,
  input  logic [SW-1:0] c,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [SW-1:0] root,
  output logic [TW-1:0] tag_out
);
  localparam int PW = 3 * SW;
  localparam int XW = PW + 3;

  // Multiplier and add stages.
  logic [2*SW-1:0] ab;
  logic [SW-1:0]   c1;
  logic [TW-1:0]   tag1, tag2, tag3;
  logic [2*SW-1:0] pl, ph;
  logic [PW-1:0]   prod;
  logic [2:0]      mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab   <= a * b;
      c1   <= c;
      tag1 <= tag_in;
      pl   <= ab[SW-1:0] * c1;
      ph   <= ab[2*SW-1:SW] * c1;
      tag2 <= tag1;
      prod <= PW'({ph, {SW{1'b0}}}) + PW'(pl);
      tag3 <= tag2;
    end
  end

  // Root stages keep y, y squared and y cubed so each trial needs only shifts and adds.
  logic [SW-1:0]   y       [SW];
  logic [2*SW-1:0] y2      [SW];
  logic [PW-1:0]   y3      [SW];
  logic [PW-1:0]   pr      [SW];
  logic [TW-1:0]   tg      [SW];
  logic [SW-1:0]   rv;

  logic [SW-1:0]   y_prev  [SW];
  logic [2*SW-1:0] y2_prev [SW];
  logic [PW-1:0]   y3_prev [SW];
  logic [PW-1:0]   pr_prev [SW];
  logic [TW-1:0]   tg_prev [SW];
  logic [SW-1:0]   y_next  [SW];
  logic [2*SW-1:0] y2_next [SW];
  logic [PW-1:0]   y3_next [SW];

  always_comb begin
    y_prev[0]  = '0;
    y2_prev[0] = '0;
    y3_prev[0] = '0;
    pr_prev[0] = prod;
    tg_prev[0] = tag3;
    for (int k = 1; k < SW; k++) begin
      y_prev[k]  = y[k-1];
      y2_prev[k] = y2[k-1];
      y3_prev[k] = y3[k-1];
      pr_prev[k] = pr[k-1];
      tg_prev[k] = tg[k-1];
    end
  end

  always_comb begin
    logic [XW-1:0] delta;
    logic [XW-1:0] trial;
    logic          take;
    int            bp;
    for (int k = 0; k < SW; k++) begin
      bp    = SW - 1 - k;
      delta = (XW'(y2_prev[k]) << bp) + (XW'(y2_prev[k]) << (bp + 1))
            + (XW'(y_prev[k]) << (2 * bp)) + (XW'(y_prev[k]) << (2 * bp + 1))
            + (XW'(1) << (3 * bp));
      trial = XW'(y3_prev[k]) + delta;
      take  = trial <= XW'(pr_prev[k]);
      y3_next[k] = take ? PW'(trial) : y3_prev[k];
      y2_next[k] = take ? (2*SW)'(XW'(y2_prev[k]) + (XW'(y_prev[k]) << (bp + 1))
                                  + (XW'(1) << (2 * bp)))
                        : y2_prev[k];
      y_next[k]  = take ? (y_prev[k] | (SW'(1) << bp)) : y_prev[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= '0;
    end else if (en) begin
      rv <= {rv[SW-2:0], mv[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SW; k++) begin
        y[k]  <= y_next[k];
        y2[k] <= y2_next[k];
        y3[k] <= y3_next[k];
        pr[k] <= pr_prev[k];
        tg[k] <= tg_prev[k];
      end
    end
  end

  assign out_valid = rv[SW-1];
  assign root      = y[SW-1];
  assign tag_out   = tg[SW-1];

endmodule

### design/tgcs_checker.sv
// Port-level checks for the three-gate confidence score unit, with the bind that attaches them.
// Depends on tgcs_pkg and three_gate_confidence_score_unit.
module tgcs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic [tgcs_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready
);
  import tgcs_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  // A valid result cannot have a zero geometric mean.
  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[68] |-> m_tdata[67:51] != '0)
    else $error("valid flag set with zero overall score");

  // Zero mixing zeroes the product, so the result is never valid.
  a_mix_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16:0] == '0 |-> !m_tdata[68] && m_tdata[67:51] == '0)
    else $error("zero mixing gave a non-zero overall score");

endmodule

bind three_gate_confidence_score_unit tgcs_checker u_tgcs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

### verif/three_gate_confidence_score_checker.sv
// Scoreboard for the three-gate confidence score unit: watches both stream sides,
// predicts each result from the accepted transaction and the live register copy.
// Depends on tgcs_pkg.
module three_gate_confidence_score_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tgcs_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tgcs_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import tgcs_pkg::*;

  localparam int FB = SCORE_FRAC_BITS_DEF;
  localparam logic [63:0] ONE = 64'd1 << FB;

  // Highest bits first, so the layout matches the result bus from bit 68 down.
  typedef struct packed {
    logic        ok;
    logic [16:0] overall;
    logic [16:0] innov;
    logic [16:0] info;
    logic [16:0] mix;
  } score_t;

  logic [16:0] stuck_acc, good_acc, floor_lvl;
  logic [23:0] conf_cnt;
  logic [19:0] low_inn, high_inn;
  score_t      score_q[$];

  assign pending = score_q.size();

  function automatic logic [63:0] cube_floor(logic [63:0] a, b, c);
    logic [127:0] prod, tc;
    logic [63:0]  y, t;
    prod = 128'(a * b) * 128'(c);
    y = 0;
    for (int i = FB; i >= 0; i--) begin
      t = y | (64'd1 << i);
      tc = 128'(t * t) * 128'(t);
      if (tc <= prod) y = t;
    end
    return y;
  endfunction

  function automatic score_t score_of(logic [16:0] acc, logic [23:0] rows,
                                      logic [19:0] norm);
    score_t      r;
    logic [63:0] mix, info, innov, ov;
    r = '0;
    if (acc < stuck_acc) return r;
    if (acc >= good_acc) mix = ONE;
    else mix = (64'(acc - stuck_acc) << FB) / 64'(good_acc - stuck_acc);
    if (rows >= conf_cnt) info = ONE;
    else if (rows == 0) info = 0;
    else info = (64'(rows) << FB) / 64'(conf_cnt);
    // The low test wins when the limits are crossed.
    if (norm < low_inn) innov = 0;
    else if (norm > high_inn) innov = mix >> 1;
    else innov = ONE;
    ov = cube_floor(mix, info, innov);
    r.mix = mix[16:0];
    r.info = info[16:0];
    r.innov = innov[16:0];
    r.overall = ov[16:0];
    r.ok = ov > 64'(floor_lvl);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    score_t want, got;
    if (rst) begin
      stuck_acc <= 17'd655;
      good_acc  <= 17'd13107;
      conf_cnt  <= 24'd12800;
      low_inn   <= 20'd655;
      high_inn  <= 20'd32768;
      floor_lvl <= 17'd6554;
      fail_count <= 0;
      score_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_STUCK_ACC: begin
            stuck_acc <= cfg_data[16:0];
          end
          CFG_GOOD_ACC: begin
            good_acc <= cfg_data[16:0];
          end
          CFG_CONF_COUNT: begin
            conf_cnt <= cfg_data;
          end
          CFG_LOW_INNOV: begin
            low_inn <= cfg_data[19:0];
          end
          CFG_HIGH_INNOV: begin
            high_inn <= cfg_data[19:0];
          end
          CFG_VALID_FLOOR: begin
            floor_lvl <= cfg_data[16:0];
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready)
        score_q.push_back(score_of(s_tdata[16:0], s_tdata[40:17], s_tdata[60:41]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[68:0];
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = score_q.pop_front();
          if (got !== want || m_tdata[71:69] !== 3'b0) begin
            $display("%0t: mismatch expected mix %0d info %0d innov %0d overall %0d ok %0d",
                     $time, want.mix, want.info, want.innov, want.overall, want.ok);
            $display("%0t:          actual mix %0d info %0d innov %0d overall %0d ok %0d",
                     $time, got.mix, got.info, got.innov, got.overall, got.ok);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/three_gate_confidence_score_unit_test.sv
// Testbench top for the three-gate confidence score unit: drives input and
// configuration traffic and gives the verdict. Depends on tgcs_pkg, the unit
// and three_gate_confidence_score_checker.
module three_gate_confidence_score_unit_test;
  import tgcs_pkg::*;

  // Pipeline latency at the default fraction width, plus some slack.
  localparam int DRAIN_CYCLES = 2 * SCORE_FRAC_BITS_DEF + 16;

  logic                  clk, rst;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tvalid, s_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tvalid, m_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, pending;
  bit                    calm;       // set for the final stretch with no idling

  three_gate_confidence_score_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  three_gate_confidence_score_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("FAIL three_gate_confidence_score_unit");
    $finish;
  end

  // The receiver stalls in random bursts, except during the calm tail.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Writes one configuration register; the unit must be idle.
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every expected result has come back, then lets the pipe settle.
  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offers one transaction, after a random idle gap unless calm, and holds it until accepted. Called at a falling edge.
  task automatic send(logic [16:0] acc, logic [23:0] rows, logic [19:0] norm);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tdata <= {3'b0, norm, rows, acc};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [16:0] pick_score();
    case ($urandom_range(0, 5))
      0: return 17'($urandom_range(0, 2000));
      1: return 17'($urandom_range(60000, 65536));
      2: return 17'(65536);
      3: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [23:0] pick_rows();
    case ($urandom_range(0, 4))
      0: return 24'($urandom_range(0, 3));
      1: return 24'($urandom);
      default: return 24'($urandom_range(0, 30000));
    endcase
  endfunction

  function automatic logic [19:0] pick_norm();
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, 1500));
      default: return 20'($urandom_range(0, 70000));
    endcase
  endfunction

  // One register setting per phase; the first three are the extremes and the rest are random.
  task automatic set_phase(int phase);
    case (phase)
      0: begin
        write_reg(CFG_STUCK_ACC, 24'd0);
        write_reg(CFG_GOOD_ACC, 24'd65536);
        write_reg(CFG_CONF_COUNT, 24'd1);
        write_reg(CFG_LOW_INNOV, 24'd0);
        write_reg(CFG_HIGH_INNOV, 24'hFFFFF);
        write_reg(CFG_VALID_FLOOR, 24'd0);
      end
      1: begin
        // Thresholds equal, limits crossed, and no confident count at all.
        write_reg(CFG_STUCK_ACC, 24'd20000);
        write_reg(CFG_GOOD_ACC, 24'd20000);
        write_reg(CFG_CONF_COUNT, 24'd0);
        write_reg(CFG_LOW_INNOV, 24'd40000);
        write_reg(CFG_HIGH_INNOV, 24'd1000);
        write_reg(CFG_VALID_FLOOR, 24'd65536);
      end
      2: begin
        write_reg(CFG_STUCK_ACC, 24'd65536);
        write_reg(CFG_GOOD_ACC, 24'd300);
        write_reg(CFG_CONF_COUNT, 24'hFFFFFF);
        write_reg(CFG_LOW_INNOV, 24'hFFFFF);
        write_reg(CFG_HIGH_INNOV, 24'd0);
        write_reg(CFG_VALID_FLOOR, 24'h1FFFF);
      end
      default: begin
        write_reg(CFG_STUCK_ACC, 24'($urandom_range(0, 8000)));
        write_reg(CFG_GOOD_ACC, 24'($urandom_range(8000, 65536)));
        write_reg(CFG_CONF_COUNT, 24'($urandom_range(1, 30000)));
        write_reg(CFG_LOW_INNOV, 24'($urandom_range(0, 2000)));
        write_reg(CFG_HIGH_INNOV, 24'($urandom_range(2000, 70000)));
        write_reg(CFG_VALID_FLOOR, 24'($urandom_range(0, 40000)));
      end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    s_tdata = '0;
    s_tvalid = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings: stuck chain, its edge, full scores,
    // zero and saturated row counts, each innovation branch, all-ones fields.
    send(17'd0, 24'd100, 20'd1000);
    send(17'd654, 24'd100, 20'd1000);
    send(17'd655, 24'd12800, 20'd1000);
    send(17'd13107, 24'd12800, 20'd1000);
    send(17'd65536, 24'd0, 20'd1000);
    send(17'd65536, 24'd1, 20'd654);
    send(17'd65536, 24'd12799, 20'd655);
    send(17'd65536, 24'hFFFFFF, 20'd32768);
    send(17'd65536, 24'd12800, 20'd32769);
    send(17'd7001, 24'd6400, 20'hFFFFF);
    send(17'h1FFFF, 24'hFFFFFF, 20'hFFFFF);
    send(17'h10000, 24'h800000, 20'h80000);
    send(17'd10000, 24'd3, 20'd40000);
    s_tvalid <= 1'b0;
    // Hold the sender until every result is back.
    drain();

    // Random part over several register settings.
    for (int phase = 0; phase < 8; phase++) begin
      set_phase(phase);
      if (phase == 7) calm = 1'b1;
      for (int n = 0; n < 240; n++)
        send(pick_score(), pick_rows(), pick_norm());
      s_tvalid <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS three_gate_confidence_score_unit");
    end else begin
      $display("FAIL three_gate_confidence_score_unit");
    end
    $finish;
  end
endmodule
